>>> design/b64dec_pkg.sv
// shared constants, types and helpers for the base64 stream decoder
// no dependencies; imported by base64_stream_decoder_unit
`timescale 1ns / 1ps

package b64dec_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int SHOW_WIDTH  = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // result status codes
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // characters with a special meaning
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PAD   = 8'h3d;

    localparam logic [5:0] SEXTET_PLUS = 6'd62;

    // one result as it leaves on the master side
    typedef struct packed {
        logic [SHOW_WIDTH-1:0] byte_count;
        logic [1:0]            status;
        logic [7:0]            out_byte;
    } result_t;

    // all results caused by one input character
    typedef struct packed {
        logic [1:0]      last_idx;
        result_t [3:0]   res;
    } pack_t;

    // bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == CH_PLUS) begin
            r = 7'd62;
        end else if (c == CH_SLASH) begin
            r = 7'd63;
        end
        return r;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // count as shown on the port, clipped to the field width
    function automatic logic [SHOW_WIDTH-1:0] count_show(input logic [COUNT_WIDTH-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'h0000_ffff) ? 16'hffff : w[SHOW_WIDTH-1:0];
    endfunction

endpackage

>>> design/base64_stream_decoder_unit.sv
// base64 stream decoder, one character per transaction, one result per transaction
// depends on b64dec_pkg
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                         tuser         tlast
// s_        in   ch[7:0]                                    start_req     -
// m_        out  out_byte[7:0] status[9:8] byte_count[25:10] -            last
//
// one character is taken per cycle; the decode of a character is a table
// lookup and bit packing done in the cycle it is accepted
// a character gives zero to four results, held as one set in a two-slot
// result buffer; the output drains one result per cycle, so the input only
// stalls while both slots hold a set (backpressure from the master side)
// aresetn is synchronous, active low; after reset input is ignored until a
// transaction with start_req set

module base64_stream_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // ch[7:0]
    input  logic [0:0]  s_tuser,    // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_byte[7:0], status[9:8], byte_count[25:10]
    output logic        m_tlast     // last result of this character
);
    import b64dec_pkg::*;

    // decoder state
    logic [1:0]             gp_reg;
    logic [5:0]             held_reg [3];
    logic                   tpad_reg;
    logic                   ats_reg;
    logic                   plus_reg;
    logic                   fin_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;

    logic [1:0]             gp_next;
    logic [5:0]             held_next [3];
    logic                   tpad_next;
    logic                   ats_next;
    logic                   plus_next;
    logic                   fin_next;
    logic [COUNT_WIDTH-1:0] cnt_next;

    // result buffer: slot a drains to the port, slot b waits behind it
    logic       a_valid_reg;
    pack_t      a_pack_reg;
    logic [1:0] a_idx_reg;
    logic       b_valid_reg;
    pack_t      b_pack_reg;

    // decode working signals
    logic                   s_accept;
    logic [7:0]             ch;
    logic                   dec;
    logic [1:0]             p;
    logic [6:0]             sx;
    logic [5:0]             v;
    logic                   pad;
    logic                   end_en;
    logic [1:0]             end_st;
    logic [1:0]             nb;
    logic [7:0]             byte_val [3];
    logic [COUNT_WIDTH-1:0] cnt_base;
    logic [COUNT_WIDTH-1:0] cnt_step [3];
    pack_t                  new_pack;
    logic                   push;

    logic                   pop;
    logic                   pop_last;
    logic                   a_free;
    result_t                cur;

    assign s_accept = s_tvalid && s_tready;
    assign ch       = s_tdata;

    always_comb begin
        gp_next   = gp_reg;
        held_next = held_reg;
        tpad_next = tpad_reg;
        ats_next  = ats_reg;
        plus_next = plus_reg;
        fin_next  = fin_reg;
        cnt_next  = cnt_reg;
        dec       = 1'b0;
        end_en    = 1'b0;
        end_st    = ST_DONE;
        nb        = 2'd0;
        p         = 2'd0;
        v         = 6'd0;
        byte_val  = '{default: 8'h00};

        // start of a new string clears everything and arms the decoder
        if (s_tuser[0]) begin
            gp_next   = 2'd0;
            held_next = '{default: 6'd0};
            tpad_next = 1'b0;
            ats_next  = 1'b1;
            plus_next = 1'b0;
            fin_next  = 1'b0;
            cnt_next  = '0;
        end
        cnt_base = cnt_next;

        // opening phase: optional "+ " prefix and the empty-string cr
        if (!fin_next) begin
            if (ats_next && !plus_next) begin
                if (ch == CH_PLUS) begin
                    plus_next = 1'b1;
                end else begin
                    ats_next = 1'b0;
                    if (ch == CH_CR) begin
                        end_en = 1'b1;
                    end else begin
                        dec = 1'b1;
                    end
                end
            end else if (ats_next) begin
                ats_next = 1'b0;
                // held plus with no space becomes the first digit
                if (ch != CH_SPACE) begin
                    plus_next    = 1'b0;
                    held_next[0] = SEXTET_PLUS;
                    gp_next      = 2'd1;
                    dec          = 1'b1;
                end
            end else if (plus_next) begin
                plus_next = 1'b0;
                if (ch == CH_CR) begin
                    end_en = 1'b1;
                end else begin
                    dec = 1'b1;
                end
            end else begin
                dec = 1'b1;
            end
        end

        p   = gp_next;
        sx  = sextet_of(ch);
        pad = (p >= 2'd2) && (ch == CH_PAD);

        if (dec) begin
            if (p == 2'd0 && cnt_next != '0 && (ch == CH_NUL || ch == CH_CR)) begin
                end_en = 1'b1;
            end else if (!pad && sx[6]) begin
                end_en = 1'b1;
                end_st = ST_ERR;
            end else begin
                v = pad ? 6'd0 : sx[5:0];
                if (p != 2'd3) begin
                    case (p)
                        2'd0:    held_next[0] = v;
                        2'd1:    held_next[1] = v;
                        default: held_next[2] = v;
                    endcase
                    if (p == 2'd2) begin
                        tpad_next = pad;
                    end
                    gp_next = p + 2'd1;
                end else begin
                    gp_next     = 2'd0;
                    byte_val[0] = {held_next[0], held_next[1][5:4]};
                    byte_val[1] = {held_next[1][3:0], held_next[2][5:2]};
                    byte_val[2] = {held_next[2][1:0], v};
                    nb          = tpad_next ? 2'd1 : (pad ? 2'd2 : 2'd3);
                    tpad_next   = 1'b0;
                    if (pad) begin
                        end_en = 1'b1;
                    end
                end
            end
        end

        if (end_en) begin
            fin_next = 1'b1;
        end

        // saturating count after each emitted byte
        cnt_step[0] = count_inc(cnt_base);
        cnt_step[1] = count_inc(cnt_step[0]);
        cnt_step[2] = count_inc(cnt_step[1]);
        case (nb)
            2'd0:    cnt_next = cnt_base;
            2'd1:    cnt_next = cnt_step[0];
            2'd2:    cnt_next = cnt_step[1];
            default: cnt_next = cnt_step[2];
        endcase

        // assemble the result set
        new_pack          = '0;
        new_pack.last_idx = 2'(3'(nb) + 3'(end_en) - 3'd1);
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nb) begin
                new_pack.res[i].out_byte   = byte_val[i];
                new_pack.res[i].status     = ST_DATA;
                new_pack.res[i].byte_count = count_show(cnt_step[i]);
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (end_en && 3'(i) == 3'(nb)) begin
                new_pack.res[i].out_byte   = 8'h00;
                new_pack.res[i].status     = end_st;
                new_pack.res[i].byte_count = count_show(cnt_next);
            end
        end
    end

    assign push = s_accept && (nb != 2'd0 || end_en);

    // output side
    assign s_tready = !b_valid_reg;
    assign cur      = a_pack_reg.res[a_idx_reg];
    assign m_tvalid = a_valid_reg;
    assign m_tdata  = {6'd0, cur.byte_count, cur.status, cur.out_byte};
    assign m_tlast  = (a_idx_reg == a_pack_reg.last_idx);
    assign pop      = m_tvalid && m_tready;
    assign pop_last = pop && m_tlast;
    assign a_free   = !a_valid_reg || (pop_last && !b_valid_reg);

    // decoder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gp_reg   <= 2'd0;
            held_reg <= '{default: 6'd0};
            tpad_reg <= 1'b0;
            ats_reg  <= 1'b1;
            plus_reg <= 1'b0;
            fin_reg  <= 1'b1;
            cnt_reg  <= '0;
        end else if (s_accept) begin
            gp_reg   <= gp_next;
            held_reg <= held_next;
            tpad_reg <= tpad_next;
            ats_reg  <= ats_next;
            plus_reg <= plus_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            a_idx_reg   <= 2'd0;
        end else begin
            if (pop && !m_tlast) begin
                a_idx_reg <= a_idx_reg + 2'd1;
            end
            if (pop_last && b_valid_reg) begin
                // b moves up; input is stalled this cycle
                a_pack_reg  <= b_pack_reg;
                a_idx_reg   <= 2'd0;
                b_valid_reg <= 1'b0;
            end else if (push) begin
                if (a_free) begin
                    a_pack_reg  <= new_pack;
                    a_idx_reg   <= 2'd0;
                    a_valid_reg <= 1'b1;
                end else begin
                    b_pack_reg  <= new_pack;
                    b_valid_reg <= 1'b1;
                end
            end else if (pop_last) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // slot b is only ever filled behind a busy slot a
    a_b_order: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> a_valid_reg)
        else $error("result slot b valid while slot a empty");

    // drain index never runs past the end of the set
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (a_idx_reg <= a_pack_reg.last_idx))
        else $error("result index beyond last result of set");

    // an error always closes the results of its character
    err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9:8] == ST_ERR) |-> m_tlast)
        else $error("error result not marked last");

    // a finished decoder stays silent until a new start
    quiet_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && fin_reg && !s_tuser[0]) |-> !push)
        else $error("result produced after done or error");

endmodule
